@@ design/spc_pkg.sv @@
package spc_pkg;

    // Default and largest sprite side in pixels.
    localparam int SPC_MAX_SIDE = 64;

    // Fixed field widths.
    localparam int ROW_W  = 64;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 7;
    localparam int ROWIX_W = 6;
    localparam int SHIFT_W = 6;
    localparam int EXT_W  = POS_W + 1;
    localparam int CFG_ADDR_W = 3;

    // Item action codes.
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_TEST   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_PERFECT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_A       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_A      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_B       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_B      = 3'd4;

    // Size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

endpackage

@@ design/spc_if.sv @@
// Input item channel: mask row loads and collision tests.
interface spc_item_if import spc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [ROWIX_W-1:0]       row_index;
    logic [ROW_W-1:0]         row_bits;
    logic signed [POS_W-1:0]  pos_a_x;
    logic signed [POS_W-1:0]  pos_a_y;
    logic signed [POS_W-1:0]  pos_b_x;
    logic signed [POS_W-1:0]  pos_b_y;

    modport source (output valid, action, row_index, row_bits,
                    pos_a_x, pos_a_y, pos_b_x, pos_b_y, input ready);
    modport sink   (input valid, action, row_index, row_bits,
                    pos_a_x, pos_a_y, pos_b_x, pos_b_y, output ready);
endinterface

// Result channel: one collided flag per test.
interface spc_result_if import spc_pkg::*; ();
    logic valid;
    logic ready;
    logic collided;

    modport source (output valid, collided, input ready);
    modport sink   (input valid, collided, output ready);
endinterface

// Configuration write channel.
interface spc_cfg_if import spc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [SIZE_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ design/sprite_pixel_collision_top.sv @@
// Sprite collision tester.
// The item channel carries three kinds of transaction: a row load for mask A,
// a row load for mask B, and a collision test with both sprite positions.
// A load gives no result. A test gives one collided flag on the result
// channel. In box mode a test goes through the edge, clip and size states to
// the done state and the result register. In pixel mode with overlapping boxes
// the scan covers the overlap rows, at most MAX_SIDE: it reads one row pair
// from the two mask memories per cycle and checks it with one shift-and-AND
// unit, and may stop early on the first hit. The item channel is not ready
// while a test runs.
// The result sits in an output register; while it waits, the block still takes
// new transactions, and a finished test holds until that register is free.
// Configuration writes are always taken and must only occur while idle.
// Reset clears the control state and sets box mode with all sides at 64; mask
// rows hold unknown data until loaded.
module sprite_pixel_collision_top
    import spc_pkg::*;
#(
    parameter int MAX_SIDE = SPC_MAX_SIDE
)
(
    input  logic         clk,
    input  logic         rst_n,
    spc_item_if.sink     item,
    spc_result_if.source result,
    spc_cfg_if.sink      cfg
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int CW = $clog2(MAX_SIDE + 1);
    localparam logic [SIZE_W-1:0] SIDE_MAX = SIZE_W'(MAX_SIDE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_CLIP,
        S_SIZE,
        S_MASK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic              pix_reg;
    logic [SIZE_W-1:0] wa_reg, ha_reg, wb_reg, hb_reg;

    // Test datapath registers.
    logic signed [EXT_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [EXT_W-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [EXT_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [SIZE_W-1:0]       w_reg;
    logic [SHIFT_W-1:0]      sa_reg, sb_reg;
    logic [ROW_W-1:0]        keep_reg;
    logic [AW-1:0]           addr_a_reg, addr_b_reg;
    logic [CW-1:0]           left_reg;
    logic                    pend_reg;
    logic                    res_reg;
    logic                    out_valid_reg;
    logic                    out_col_reg;

    // Mask memories and their read registers.
    logic [ROW_W-1:0] mask_a_mem [MAX_SIDE];
    logic [ROW_W-1:0] mask_b_mem [MAX_SIDE];
    logic [ROW_W-1:0] rd_a_reg, rd_b_reg;

    logic              item_fire, test_fire, row_ok, load_a, load_b;
    logic [AW-1:0]     wr_addr;
    logic [SIZE_W-1:0] side_wa, side_ha, side_wb, side_hb;
    logic              overlap, issue, hit, out_load;

    // Handshake outputs.
    assign item.ready      = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.collided = out_col_reg;

    // Transaction decode.
    assign item_fire = item.valid && item.ready;
    assign test_fire = item_fire && (item.action == ACT_TEST);
    assign row_ok    = ({1'b0, item.row_index} < SIZE_W'(MAX_SIDE));
    assign load_a    = item_fire && (item.action == ACT_LOAD_A) && row_ok;
    assign load_b    = item_fire && (item.action == ACT_LOAD_B) && row_ok;
    assign wr_addr   = item.row_index[AW-1:0];

    // Sides clamped to the mask size.
    assign side_wa = (wa_reg > SIDE_MAX) ? SIDE_MAX : wa_reg;
    assign side_ha = (ha_reg > SIDE_MAX) ? SIDE_MAX : ha_reg;
    assign side_wb = (wb_reg > SIDE_MAX) ? SIDE_MAX : wb_reg;
    assign side_hb = (hb_reg > SIDE_MAX) ? SIDE_MAX : hb_reg;

    assign overlap = (x1_reg > x0_reg) && (y1_reg > y0_reg);
    assign issue   = (left_reg != '0);
    assign hit     = (((rd_a_reg >> sa_reg) & (rd_b_reg >> sb_reg) & keep_reg) != '0);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= 1'b0;
            wa_reg  <= SIZE_RESET;
            ha_reg  <= SIZE_RESET;
            wb_reg  <= SIZE_RESET;
            hb_reg  <= SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                REG_PIXEL_PERFECT: pix_reg <= cfg.data[0];
                REG_WIDTH_A:       wa_reg  <= cfg.data;
                REG_HEIGHT_A:      ha_reg  <= cfg.data;
                REG_WIDTH_B:       wb_reg  <= cfg.data;
                REG_HEIGHT_B:      hb_reg  <= cfg.data;
                default:           ;
            endcase
        end
    end

    // Mask A: row writes from load transactions, registered reads for the scan.
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            mask_a_mem[wr_addr] <= item.row_bits;
        end
        rd_a_reg <= mask_a_mem[addr_a_reg];
    end

    // Mask B: same organization as mask A.
    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            mask_b_mem[wr_addr] <= item.row_bits;
        end
        rd_b_reg <= mask_b_mem[addr_b_reg];
    end

    // Sequencer: state and registered result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (test_fire)
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    state_reg <= S_CLIP;
                end
                S_CLIP:
                begin
                    state_reg <= S_SIZE;
                end
                S_SIZE:
                begin
                    if (!overlap)
                    begin
                        res_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (!pix_reg)
                    begin
                        res_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        left_reg  <= CW'(y1_reg - y0_reg);
                        state_reg <= S_MASK;
                    end
                end
                S_MASK:
                begin
                    pend_reg  <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        left_reg <= left_reg - 1'b1;
                    end
                    pend_reg <= issue;
                    if (pend_reg && hit)
                    begin
                        res_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (!issue && !pend_reg)
                    begin
                        res_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: one step of the bound and scan arithmetic per state.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (test_fire)
                begin
                    ax_reg <= EXT_W'(item.pos_a_x);
                    ay_reg <= EXT_W'(item.pos_a_y);
                    bx_reg <= EXT_W'(item.pos_b_x);
                    by_reg <= EXT_W'(item.pos_b_y);
                end
            end
            S_EDGE:
            begin
                ax1_reg <= ax_reg + $signed({{(EXT_W-SIZE_W){1'b0}}, side_wa});
                ay1_reg <= ay_reg + $signed({{(EXT_W-SIZE_W){1'b0}}, side_ha});
                bx1_reg <= bx_reg + $signed({{(EXT_W-SIZE_W){1'b0}}, side_wb});
                by1_reg <= by_reg + $signed({{(EXT_W-SIZE_W){1'b0}}, side_hb});
            end
            S_CLIP:
            begin
                x0_reg <= (ax_reg > bx_reg) ? ax_reg : bx_reg;
                y0_reg <= (ay_reg > by_reg) ? ay_reg : by_reg;
                x1_reg <= (ax1_reg < bx1_reg) ? ax1_reg : bx1_reg;
                y1_reg <= (ay1_reg < by1_reg) ? ay1_reg : by1_reg;
            end
            S_SIZE:
            begin
                w_reg      <= SIZE_W'(x1_reg - x0_reg);
                sa_reg     <= SHIFT_W'(x0_reg - ax_reg);
                sb_reg     <= SHIFT_W'(x0_reg - bx_reg);
                addr_a_reg <= AW'(y0_reg - ay_reg);
                addr_b_reg <= AW'(y0_reg - by_reg);
            end
            S_MASK:
            begin
                // Overlap columns, counted from the left edge of the overlap.
                if (w_reg >= SIZE_W'(ROW_W))
                begin
                    keep_reg <= '1;
                end
                else
                begin
                    keep_reg <= (ROW_W'(1) << w_reg[SHIFT_W-1:0]) - ROW_W'(1);
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    addr_a_reg <= addr_a_reg + 1'b1;
                    addr_b_reg <= addr_b_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_col_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // A test transaction always starts the bound computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        test_fire |=> state_reg == S_EDGE)
        else $error("test transaction did not start the sequencer");

    // The row counter never exceeds the mask height.
    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= CW'(MAX_SIDE))
        else $error("scan row count out of range");

    // Every row read during the scan lies inside both masks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && issue |->
        ({1'b0, addr_a_reg} < (AW+1)'(MAX_SIDE)) &&
        ({1'b0, addr_b_reg} < (AW+1)'(MAX_SIDE)))
        else $error("scan read outside the mask memory");

    // Box mode never scans the masks.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> pix_reg)
        else $error("pixel scan in box mode");

    // A new result appears only when a test finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised without a finished test");

endmodule

@@ test/spc_collision_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and configuration channels of the sprite collision
// block. It keeps its own copy of both opacity masks and of the registers,
// predicts the collided flag of every accepted test transaction, and compares
// each accepted result transaction with the oldest outstanding prediction.
module spc_collision_checker
    import spc_pkg::*;
#(
    parameter int MAX_SIDE = SPC_MAX_SIDE
)
(
    input  logic  clk,
    input  logic  rst_n,
    spc_item_if   item,
    spc_result_if result,
    spc_cfg_if    cfg,
    output int    fail_count,
    output int    pending
);

    // Shadow copies of the mask memories and of the configuration registers.
    logic [ROW_W-1:0]  mask_a_rows [MAX_SIDE];
    logic [ROW_W-1:0]  mask_b_rows [MAX_SIDE];
    logic              pixel_mode;
    logic [SIZE_W-1:0] width_a;
    logic [SIZE_W-1:0] height_a;
    logic [SIZE_W-1:0] width_b;
    logic [SIZE_W-1:0] height_b;

    // Collided flags still owed by the block, oldest first.
    logic              expected_collided [$];

    // A side above MAX_SIDE counts as MAX_SIDE; a side of zero stays empty.
    function automatic int clamp_side(input logic [SIZE_W-1:0] v);
        return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    // Collided flag for two sprites at the given corners under the current
    // registers and masks.
    function automatic logic predict_collided(
        input logic signed [POS_W-1:0] a_x,
        input logic signed [POS_W-1:0] a_y,
        input logic signed [POS_W-1:0] b_x,
        input logic signed [POS_W-1:0] b_y
    );
        int ax, ay, bx, by;
        int ax_end, ay_end, bx_end, by_end;
        int x_lo, x_hi, y_lo, y_hi;
        int span, shift_a, shift_b, row_a, row_b, y;
        logic [ROW_W-1:0] keep;
        logic [ROW_W-1:0] bits_a;
        logic [ROW_W-1:0] bits_b;

        ax = a_x;
        ay = a_y;
        bx = b_x;
        by = b_y;
        ax_end = ax + clamp_side(width_a);
        ay_end = ay + clamp_side(height_a);
        bx_end = bx + clamp_side(width_b);
        by_end = by + clamp_side(height_b);
        x_lo = (ax > bx) ? ax : bx;
        x_hi = (ax_end < bx_end) ? ax_end : bx_end;
        y_lo = (ay > by) ? ay : by;
        y_hi = (ay_end < by_end) ? ay_end : by_end;

        // Rectangles that only touch along an edge have no common area.
        if (x_hi <= x_lo || y_hi <= y_lo)
            return 1'b0;
        if (!pixel_mode)
            return 1'b1;

        // Align both masks to the left edge of the overlap and scan its rows.
        span = x_hi - x_lo;
        shift_a = x_lo - ax;
        shift_b = x_lo - bx;
        keep = (span >= ROW_W) ? '1 : ((64'd1 << span) - 64'd1);
        for (y = y_lo; y < y_hi; y++)
        begin
            row_a = y - ay;
            row_b = y - by;
            if (row_a < 0 || row_a >= MAX_SIDE || row_b < 0 || row_b >= MAX_SIDE)
                continue;
            if (shift_a > ROW_W - 1 || shift_b > ROW_W - 1)
                continue;
            bits_a = mask_a_rows[row_a] >> shift_a;
            bits_b = mask_b_rows[row_b] >> shift_b;
            if ((bits_a & bits_b & keep) != '0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Track register writes, check results, then predict newly accepted tests.
    always @(posedge clk or negedge rst_n)
    begin
        logic want;

        if (!rst_n)
        begin
            pixel_mode = 1'b0;
            width_a = SIZE_RESET;
            height_a = SIZE_RESET;
            width_b = SIZE_RESET;
            height_b = SIZE_RESET;
            expected_collided.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Register write transactions.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_PIXEL_PERFECT: pixel_mode = cfg.data[0];
                    REG_WIDTH_A:       width_a = cfg.data;
                    REG_HEIGHT_A:      height_a = cfg.data;
                    REG_WIDTH_B:       width_b = cfg.data;
                    REG_HEIGHT_B:      height_b = cfg.data;
                    default:           ;
                endcase
            end

            // Result transactions are matched in order against the predictions.
            if (result.valid && result.ready)
            begin
                if (expected_collided.size() == 0)
                begin
                    report_mismatch($sformatf("result collided=%b with no test outstanding",
                                              result.collided));
                end
                else
                begin
                    want = expected_collided.pop_front();
                    if (result.collided !== want)
                        report_mismatch($sformatf("collided got %b expected %b",
                                                  result.collided, want));
                end
            end

            // Item transactions: loads update the masks, tests owe one flag.
            if (item.valid && item.ready)
            begin
                case (item.action)
                    ACT_LOAD_A:
                    begin
                        if (int'(item.row_index) < MAX_SIDE)
                            mask_a_rows[item.row_index] = item.row_bits;
                    end
                    ACT_LOAD_B:
                    begin
                        if (int'(item.row_index) < MAX_SIDE)
                            mask_b_rows[item.row_index] = item.row_bits;
                    end
                    ACT_TEST:
                    begin
                        expected_collided.push_back(predict_collided(item.pos_a_x,
                            item.pos_a_y, item.pos_b_x, item.pos_b_y));
                    end
                    default: ;
                endcase
            end

            pending = expected_collided.size();
        end
    end

endmodule

@@ test/tb_sprite_pixel_collision_top.sv @@
`timescale 1ns / 1ps

module tb_sprite_pixel_collision_top;
    import spc_pkg::*;

    localparam int MAX_SIDE     = SPC_MAX_SIDE;
    localparam int QUIET_CYCLES = MAX_SIDE + 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 132;

    // The fourth action code and an index past the last register: both ignored.
    localparam logic [1:0]            ACT_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE  = 3'd7;

    typedef struct {
        logic [1:0]              action;
        logic [ROWIX_W-1:0]      row_index;
        logic [ROW_W-1:0]        row_bits;
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
    } spc_txn_t;

    logic clk;
    logic rst_n;
    logic calm;
    int   cycle_count;
    int   stall_left;
    int   fail_count;
    int   pending;

    spc_item_if   item_ch();
    spc_result_if result_ch();
    spc_cfg_if    cfg_ch();

    sprite_pixel_collision_top #(.MAX_SIDE(MAX_SIDE)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    spc_collision_checker #(.MAX_SIDE(MAX_SIDE)) collision_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sprite_pixel_collision_top regression: fail");
            $finish;
        end
    end

    // Result backpressure in random bursts, none in the calm tail.
    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            result_ch.ready <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Mostly sparse rows so that pixel tests both hit and miss.
    function automatic logic [ROW_W-1:0] random_row_bits();
        case ($urandom_range(0, 9))
            0, 1, 2:    return '0;
            3, 4, 5:    return 64'd1 << $urandom_range(0, ROW_W - 1);
            6, 7:       return {$urandom, $urandom} & {$urandom, $urandom}
                               & {$urandom, $urandom} & {$urandom, $urandom};
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic spc_txn_t make_load(input logic [1:0] action, input int row,
                                           input logic [ROW_W-1:0] bits);
        spc_txn_t t;

        t.action = action;
        t.row_index = ROWIX_W'(row);
        t.row_bits = bits;
        t.pos_a_x = POS_W'($urandom);
        t.pos_a_y = POS_W'($urandom);
        t.pos_b_x = POS_W'($urandom);
        t.pos_b_y = POS_W'($urandom);
        return t;
    endfunction

    function automatic spc_txn_t make_test(input int ax, input int ay,
                                           input int bx, input int by);
        spc_txn_t t;

        t.action = ACT_TEST;
        t.row_index = ROWIX_W'($urandom);
        t.row_bits = {$urandom, $urandom};
        t.pos_a_x = POS_W'(ax);
        t.pos_a_y = POS_W'(ay);
        t.pos_b_x = POS_W'(bx);
        t.pos_b_y = POS_W'(by);
        return t;
    endfunction

    // Test positions: mostly near each other so the boxes overlap partly,
    // some at the ends of the coordinate range, some anywhere at all.
    function automatic spc_txn_t random_test(input int reach);
        int kind, ax, ay, bx, by;

        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                ax = int'($urandom_range(0, 65535)) - 32768;
                ay = int'($urandom_range(0, 65535)) - 32768;
                bx = int'($urandom_range(0, 65535)) - 32768;
                by = int'($urandom_range(0, 65535)) - 32768;
            end
            1:
            begin
                ax = 32767 - int'($urandom_range(0, reach));
                ay = 32767 - int'($urandom_range(0, reach));
            end
            2:
            begin
                ax = -32768 + int'($urandom_range(0, reach));
                ay = -32768 + int'($urandom_range(0, reach));
            end
            default:
            begin
                ax = int'($urandom_range(0, 400)) - 200;
                ay = int'($urandom_range(0, 400)) - 200;
            end
        endcase
        if (kind != 0)
        begin
            bx = ax + int'($urandom_range(0, 2 * reach)) - reach;
            by = ay + int'($urandom_range(0, 2 * reach)) - reach;
        end
        return make_test(ax, ay, bx, by);
    endfunction

    function automatic spc_txn_t random_item(input int reach);
        spc_txn_t t;
        int pick;

        pick = $urandom_range(0, 19);
        if (pick < 5)
            t = make_load(ACT_LOAD_A, $urandom_range(0, MAX_SIDE - 1), random_row_bits());
        else if (pick < 9)
            t = make_load(ACT_LOAD_B, $urandom_range(0, MAX_SIDE - 1), random_row_bits());
        else if (pick == 9)
            t = make_load(ACT_UNUSED, $urandom_range(0, MAX_SIDE - 1), {$urandom, $urandom});
        else
            t = random_test(reach);
        return t;
    endfunction

    // Present one item transaction, with an optional idle gap in front,
    // and return at the edge where it is accepted.
    task automatic send_transaction(input spc_txn_t t);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= t.action;
        item_ch.row_index <= t.row_index;
        item_ch.row_bits <= t.row_bits;
        item_ch.pos_a_x <= t.pos_a_x;
        item_ch.pos_a_y <= t.pos_a_y;
        item_ch.pos_b_x <= t.pos_b_x;
        item_ch.pos_b_y <= t.pos_b_y;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Stop sending, wait for every owed result, then let the block sit idle.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [SIZE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= addr;
        cfg_ch.data <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Reconfigure while idle. Upper data bits of the mode register are junk.
    task automatic apply_config(input logic mode, input int wa, input int ha,
                                input int wb, input int hb, input logic spare);
        drain_results();
        write_register(REG_PIXEL_PERFECT, {(SIZE_W - 1)'($urandom), mode});
        write_register(REG_WIDTH_A, SIZE_W'(wa));
        write_register(REG_HEIGHT_A, SIZE_W'(ha));
        write_register(REG_WIDTH_B, SIZE_W'(wb));
        write_register(REG_HEIGHT_B, SIZE_W'(hb));
        if (spare)
            write_register(REG_SPARE, SIZE_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin
        spc_txn_t t;
        logic [ROW_W-1:0] bits_a;
        logic [ROW_W-1:0] bits_b;
        logic mode;
        int ph, i, r, wa, ha, wb, hb, reach;

        rst_n = 1'b0;
        calm = 1'b0;
        cycle_count = 0;
        stall_left = 0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD_A;
        item_ch.row_index = '0;
        item_ch.row_bits = '0;
        item_ch.pos_a_x = '0;
        item_ch.pos_a_y = '0;
        item_ch.pos_b_x = '0;
        item_ch.pos_b_y = '0;
        result_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = REG_PIXEL_PERFECT;
        cfg_ch.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Load every row of both masks so no test reads an unwritten row.
        // Corner rows are fixed so the directed pixel tests know what to hit.
        for (r = 0; r < MAX_SIDE; r++)
        begin
            bits_a = (r == 0) ? '1 : (r == MAX_SIDE - 1) ? {1'b1, 63'd0} : random_row_bits();
            bits_b = (r == 0) ? 64'd1 : (r == MAX_SIDE - 1) ? '1 : random_row_bits();
            send_transaction(make_load(ACT_LOAD_A, r, bits_a));
            send_transaction(make_load(ACT_LOAD_B, r, bits_b));
        end

        // Box mode with the reset sizes: overlap, touching edges, range ends.
        send_transaction(make_test(0, 0, 0, 0));
        send_transaction(make_test(0, 0, 64, 0));
        send_transaction(make_test(0, 0, 0, 64));
        send_transaction(make_test(0, 0, 63, 63));
        send_transaction(make_test(-1, -1, -64, -64));
        send_transaction(make_test(32767, 32767, 32767, -32768));
        send_transaction(make_test(32767, 32767, 32767, 32767));
        send_transaction(make_test(-32768, -32768, -32705, -32705));
        send_transaction(make_load(ACT_UNUSED, MAX_SIDE - 1, '1));

        // Pixel mode on the fixed corner rows.
        apply_config(1'b1, 64, 64, 64, 64, 1'b0);
        send_transaction(make_test(0, 0, 0, 0));
        send_transaction(make_test(0, 0, 63, 63));
        send_transaction(make_test(0, 0, 64, 0));
        send_transaction(make_test(0, 0, -63, -63));
        send_transaction(make_test(5, 0, 0, 60));

        // An empty sprite never collides; an oversize one counts as full size.
        apply_config(1'b1, 0, 64, 64, 64, 1'b0);
        send_transaction(make_test(0, 0, 0, 0));
        apply_config(1'b1, 127, 127, 64, 64, 1'b1);
        send_transaction(make_test(0, 0, 0, 0));
        send_transaction(make_test(-63, -63, 0, 0));

        // Random phases, each with its own register setting.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin mode = 1'b1; wa = 64; ha = 64; wb = 64; hb = 64; end
                1: begin mode = 1'b0; wa = 1; ha = 1; wb = 1; hb = 1; end
                2: begin mode = 1'b1; wa = 1; ha = 1; wb = 1; hb = 1; end
                4: begin mode = 1'b0; wa = 0; ha = 64; wb = 127; hb = 5; end
                5: begin mode = 1'b1; wa = 127; ha = 0; wb = 33; hb = 64; end
                6:
                begin
                    mode = 1'b1;
                    wa = $urandom_range(1, 16);
                    ha = $urandom_range(1, 16);
                    wb = $urandom_range(1, 16);
                    hb = $urandom_range(1, 16);
                end
                7:
                begin
                    mode = 1'b0;
                    wa = $urandom_range(1, 64);
                    ha = $urandom_range(1, 64);
                    wb = $urandom_range(1, 64);
                    hb = $urandom_range(1, 64);
                end
                8:
                begin
                    mode = 1'b1;
                    wa = $urandom_range(0, 127);
                    ha = $urandom_range(0, 127);
                    wb = $urandom_range(0, 127);
                    hb = $urandom_range(0, 127);
                end
                default:
                begin
                    mode = 1'b1;
                    wa = $urandom_range(1, 64);
                    ha = $urandom_range(1, 64);
                    wb = $urandom_range(1, 64);
                    hb = $urandom_range(1, 64);
                end
            endcase
            apply_config(mode, wa, ha, wb, hb, 1'b0);
            if (ph == NUM_PHASES - 1)
                calm <= 1'b1;

            // Offsets reach a little past the largest side in use.
            reach = 2;
            if (wa > reach) reach = wa;
            if (ha > reach) reach = ha;
            if (wb > reach) reach = wb;
            if (hb > reach) reach = hb;
            if (reach > MAX_SIDE) reach = MAX_SIDE;
            reach = reach + 2;

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Now and then hold off until every result is in.
                if (i == PHASE_ITEMS / 2 && ph % 2 == 1)
                    drain_results();
                t = random_item(reach);
                send_transaction(t);
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("sprite_pixel_collision_top regression: pass");
        else
            $display("sprite_pixel_collision_top regression: fail");
        $finish;
    end

endmodule
